// ----- rtl/sha256_stream_hasher_assert.svh -----
// Assertion macros shared by the hasher modules.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/sha_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 hasher.
package sha_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } core_state_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte  = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ----- rtl/sha256_stream_hasher.sv -----
// Top level of the streaming SHA-256 hasher.
// Bytes arrive one per transfer into a four-entry queue; the item that carries
// end_of_message closes the message and may hold a byte or none. The core takes
// one queued item per cycle while idle into a 64-byte block buffer. A full block
// holds the core for 64 rounds (one round a cycle on one shared round unit) and
// a fold into the chaining words, and no byte is taken meanwhile. The end of a
// message adds padding written one byte a cycle (one or two pad blocks, each
// followed by a compression), then the eight digest words leave one a cycle
// while the output is not stalled, the last one marked. Input stalls once the
// queue fills while the core compresses, pads or emits.
module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic        last_word
);

    sha_pkg::item_t in_item;
    sha_pkg::item_t q_item;
    logic           q_valid;
    logic           q_stall;

    assign in_item.data_byte      = data_byte;
    assign in_item.byte_present   = byte_present;
    assign in_item.end_of_message = end_of_message;

    sha_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_stall (q_stall),
        .out_item  (q_item)
    );

    sha_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_valid),
        .item_stall  (q_stall),
        .item        (q_item),
        .valid       (out_valid),
        .stall       (out_stall),
        .digest_word (digest_word),
        .last_word   (last_word)
    );

endmodule

// ----- rtl/sha_queue.sv -----
// Short item queue between the input front and the hashing core.
module sha_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sha_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_stall,
    output sha_pkg::item_t  out_item
);

    `include "sha256_stream_hasher_assert.svh"

    sha_pkg::item_t                   mem_reg [sha_pkg::QueueDepth];
    logic [sha_pkg::QueuePtrW-1:0]    wr_ptr_reg;
    logic [sha_pkg::QueuePtrW-1:0]    rd_ptr_reg;
    logic [sha_pkg::QueuePtrW:0]      count_reg;
    logic [sha_pkg::QueuePtrW:0]      count_next;
    logic                             push;
    logic                             pop;

    assign in_stall  = (count_reg == sha_pkg::QueuePtrW'(0) + (sha_pkg::QueuePtrW+1)'(sha_pkg::QueueDepth));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store transfers
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    `SHA_ASSERT_IMPL(a_no_overflow, clk, rst_n, 1'b1, count_reg <= (sha_pkg::QueuePtrW+1)'(sha_pkg::QueueDepth))
    `SHA_ASSERT_NEXT(a_push_counts, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `SHA_ASSERT_NEXT(a_pop_counts, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

// ----- rtl/sha_core.sv -----
// SHA-256 compression core: block buffer, padding, 64 rounds, digest output.
module sha_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  sha_pkg::item_t  item,
    output logic            valid,
    input  logic            stall,
    output logic [31:0]     digest_word,
    output logic            last_word
);

    `include "sha256_stream_hasher_assert.svh"

    sha_pkg::core_state_t state_reg;
    sha_pkg::core_state_t state_next;

    logic [31:0] blk_reg   [16];
    logic [31:0] sched_reg [16];
    logic [31:0] chain_reg [8];
    logic [31:0] work_reg  [8];
    logic [63:0] bit_count_reg;
    logic [5:0]  round_reg;
    logic [5:0]  pad_pos_reg;
    logic        final_reg;
    logic        two_blocks_reg;
    logic        mark_reg;
    logic [2:0]  out_idx_reg;

    logic        take;
    logic        block_full;
    logic [5:0]  fill_pos;
    logic [5:0]  pad_start;
    logic [31:0] w_cur;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [7:0]  pad_byte;
    logic        pad_done;

    assign fill_pos   = bit_count_reg[8:3];
    assign take       = item_valid && !item_stall;
    assign block_full = item.byte_present && (fill_pos == 6'd63);
    assign pad_start  = item.byte_present ? fill_pos + 6'd1 : fill_pos;

    // Round datapath
    always_comb
    begin
        if (round_reg < 6'd16)
        begin
            w_cur = blk_reg[round_reg[3:0]];
        end
        else
        begin
            w_cur = sched_reg[round_reg[3:0]]
                  + sha_pkg::sig0(sched_reg[4'(round_reg[3:0] + 4'd1)])
                  + sched_reg[4'(round_reg[3:0] + 4'd9)]
                  + sha_pkg::sig1(sched_reg[4'(round_reg[3:0] + 4'd14)]);
        end
        t1 = work_reg[7] + sha_pkg::bsig1(work_reg[4])
           + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
           + sha_pkg::RK[round_reg] + w_cur;
        t2 = sha_pkg::bsig0(work_reg[0])
           + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));
    end

    // Padding byte: the end marker first, then zeros, then the length in the
    // last eight slots of the final block
    always_comb
    begin
        pad_byte = 8'h00;
        if (mark_reg)
        begin
            pad_byte = sha_pkg::PadByte;
        end
        else if (!two_blocks_reg && pad_pos_reg >= sha_pkg::LenStart)
        begin
            pad_byte = bit_count_reg[{~pad_pos_reg[2:0], 3'b000} +: 8];
        end
        pad_done = (pad_pos_reg == 6'd63);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (take && block_full)
                begin
                    state_next = sha_pkg::ST_ROUND;
                end
                else if (take && item.end_of_message)
                begin
                    state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_PAD:
            begin
                if (pad_done)
                begin
                    state_next = sha_pkg::ST_ROUND;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_FOLD;
                end
            end
            sha_pkg::ST_FOLD:
            begin
                if (!final_reg)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
                else if (two_blocks_reg)
                begin
                    state_next = sha_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha_pkg::ST_OUT;
                end
            end
            sha_pkg::ST_OUT:
            begin
                if (!stall && out_idx_reg == 3'd7)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        item_stall  = (state_reg != sha_pkg::ST_IDLE);
        valid       = (state_reg == sha_pkg::ST_OUT);
        digest_word = chain_reg[out_idx_reg];
        last_word   = (out_idx_reg == 3'd7);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sha_pkg::ST_IDLE;
            bit_count_reg  <= '0;
            round_reg      <= '0;
            pad_pos_reg    <= '0;
            final_reg      <= 1'b0;
            two_blocks_reg <= 1'b0;
            mark_reg       <= 1'b0;
            out_idx_reg    <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha_pkg::IV[i];
                work_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                sha_pkg::ST_IDLE:
                begin
                    round_reg <= '0;
                    if (take)
                    begin
                        if (item.byte_present)
                        begin
                            bit_count_reg <= bit_count_reg + 64'd8;
                        end
                        // a full block is hashed first and the marker opens a fresh pad block
                        if (item.end_of_message)
                        begin
                            final_reg <= 1'b1;
                            mark_reg  <= 1'b1;
                            if (block_full)
                            begin
                                two_blocks_reg <= 1'b1;
                                pad_pos_reg    <= '0;
                            end
                            else
                            begin
                                two_blocks_reg <= (pad_start >= sha_pkg::LenStart);
                                pad_pos_reg    <= pad_start;
                            end
                        end
                        if (block_full)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                work_reg[i] <= chain_reg[i];
                            end
                        end
                    end
                end
                sha_pkg::ST_PAD:
                begin
                    pad_pos_reg <= pad_pos_reg + 6'd1;
                    mark_reg    <= 1'b0;
                    round_reg   <= '0;
                    if (pad_done)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            work_reg[i] <= chain_reg[i];
                        end
                    end
                end
                sha_pkg::ST_ROUND:
                begin
                    round_reg   <= round_reg + 6'd1;
                    work_reg[7] <= work_reg[6];
                    work_reg[6] <= work_reg[5];
                    work_reg[5] <= work_reg[4];
                    work_reg[4] <= work_reg[3] + t1;
                    work_reg[3] <= work_reg[2];
                    work_reg[2] <= work_reg[1];
                    work_reg[1] <= work_reg[0];
                    work_reg[0] <= t1 + t2;
                end
                sha_pkg::ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                    if (two_blocks_reg)
                    begin
                        two_blocks_reg <= 1'b0;
                        pad_pos_reg    <= '0;
                    end
                    out_idx_reg <= '0;
                end
                sha_pkg::ST_OUT:
                begin
                    if (!stall)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            bit_count_reg <= '0;
                            final_reg     <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                chain_reg[i] <= sha_pkg::IV[i];
                                work_reg[i]  <= '0;
                            end
                        end
                    end
                end
                default:
                begin
                    round_reg <= '0;
                end
            endcase
        end
    end

    // Block buffer and schedule ring writes, big-endian byte lanes
    always_ff @(posedge clk)
    begin
        if (take && item.byte_present)
        begin
            blk_reg[fill_pos[5:2]][{~fill_pos[1:0], 3'b000} +: 8] <= item.data_byte;
        end
        else if (state_reg == sha_pkg::ST_PAD)
        begin
            blk_reg[pad_pos_reg[5:2]][{~pad_pos_reg[1:0], 3'b000} +: 8] <= pad_byte;
        end
        if (state_reg == sha_pkg::ST_ROUND)
        begin
            sched_reg[round_reg[3:0]] <= w_cur;
        end
    end

    `SHA_ASSERT_IMPL(a_out_only_final, clk, rst_n, valid, final_reg)
    `SHA_ASSERT_IMPL(a_stall_busy, clk, rst_n, state_reg == sha_pkg::ST_ROUND, item_stall)
    `SHA_ASSERT_NEXT(a_round_to_fold, clk, rst_n,
        state_reg == sha_pkg::ST_ROUND && round_reg == 6'd63, state_reg == sha_pkg::ST_FOLD)

endmodule

// ----- tb/sv/sha256_stream_hasher_test.sv -----
// Testbench for the streaming SHA-256 hasher: directed and random messages checked against a predictor.
module sha256_stream_hasher_test;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic        last_word;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } digest_out_t;

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       eom;
        logic       known;     // expected digest typed in below
        logic [31:0] word0;
    } stim_row_t;

    // Hasher state kept by the predictor
    logic [31:0] chain_st [8];
    logic [7:0]  buf_st [64];
    logic [63:0] len_bits;

    digest_out_t digest_queue [$];
    int          fail_count;
    int          digests_seen;
    int          msgs_sent;
    int          out_wait;

    localparam logic [31:0] H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] KR [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    sha256_stream_hasher u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .last_word      (last_word)
    );

    // Generate the clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run one 64-round compression over the buffered block
    task automatic compress_buffer();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int j = 0; j < 64; j++)
        begin
            if (j < 16)
                w[j] = {buf_st[4*j], buf_st[4*j+1], buf_st[4*j+2], buf_st[4*j+3]};
            else
                w[j] = w[j-16] + w[j-7]
                     + (ror32(w[j-15], 7) ^ ror32(w[j-15], 18) ^ (w[j-15] >> 3))
                     + (ror32(w[j-2], 17) ^ ror32(w[j-2], 19) ^ (w[j-2] >> 10));
        end
        for (int j = 0; j < 8; j++)
            v[j] = chain_st[j];
        for (int j = 0; j < 64; j++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KR[j] + w[j];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            chain_st[j] = chain_st[j] + v[j];
    endtask

    task automatic clear_message();
        for (int j = 0; j < 8; j++)
            chain_st[j] = H0[j];
        len_bits = '0;
    endtask

    // Absorb one transfer and queue the digest words it causes
    task automatic predict_digest(input logic [7:0] d, input logic p, input logic e);
        int pos;
        digest_out_t r;
        if (p)
        begin
            pos = len_bits[8:3];
            buf_st[pos] = d;
            len_bits = len_bits + 64'd8;
            if (pos == 63)
                compress_buffer();
        end
        if (!e)
            return;
        pos = len_bits[8:3];
        buf_st[pos] = 8'h80;
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                buf_st[pos] = 8'h00;
                pos++;
            end
            compress_buffer();
            pos = 0;
        end
        while (pos < 56)
        begin
            buf_st[pos] = 8'h00;
            pos++;
        end
        for (int k = 0; k < 8; k++)
            buf_st[56+k] = len_bits[63-8*k -: 8];
        compress_buffer();
        for (int k = 0; k < 8; k++)
        begin
            r.word = chain_st[k];
            r.last = (k == 7);
            digest_queue.insert(digest_queue.size(), r);
        end
        clear_message();
    endtask

    // Drive one item and hold it until the transfer
    task automatic send_item(input logic [7:0] d, input logic p, input logic e);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= d;
        byte_present   <= p;
        end_of_message <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_digest(d, p, e);
        if (e)
            msgs_sent++;
    endtask

    // Drop valid and wait until every expected digest word has come out
    task automatic drain_digests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (digest_queue.size() != 0)
            @(posedge clk);
    endtask

    // Send a message of n random bytes, end marker with or without a byte
    task automatic send_message(input int n, input bit end_with_byte);
        bit tail_byte;
        tail_byte = (n > 0) && end_with_byte;
        for (int j = 0; j < n - int'(tail_byte); j++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), tail_byte, 1'b1);
    endtask

    // Stall the output for a drawn number of cycles and check each digest transfer
    always @(posedge clk)
    begin
        digest_out_t exp_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_queue.size() == 0)
                begin
                    $error("digest_word with nothing expected: %h", digest_word);
                    fail_count++;
                end
                else
                begin
                    exp_r = digest_queue.pop_front();
                    digests_seen++;
                    if (digest_word !== exp_r.word)
                    begin
                        $error("digest_word expected %h actual %h", exp_r.word, digest_word);
                        fail_count++;
                    end
                    if (last_word !== exp_r.last)
                    begin
                        $error("last_word expected %b actual %b", exp_r.last, last_word);
                        fail_count++;
                    end
                end
                out_wait = $urandom_range(0, 10);
            end
            else if (out_wait > 0)
            begin
                out_wait--;
            end
            out_stall <= (out_wait != 0);
        end
        else
        begin
            out_wait = 0;
            out_stall <= 1'b0;
        end
    end

    // Directed rows: empty, "abc", edge bytes, noise
    stim_row_t dir_rows [10];

    initial
    begin
        stim_row_t row;
        dir_rows = '{
            '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
            '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
            '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},
            '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
            '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
            '{8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'h7f, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'haa, 1'b0, 1'b1, 1'b0, 32'h0}
        };
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = '0;
        byte_present   = 1'b0;
        end_of_message = 1'b0;
        fail_count     = 0;
        digests_seen   = 0;
        msgs_sent      = 0;
        for (int j = 0; j < 64; j++)
            buf_st[j] = 8'h00;
        clear_message();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table; typed-in first words are checked against the predictor
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_item(row.data, row.present, row.eom);
            if (row.known && digest_queue[digest_queue.size()-8].word !== row.word0)
            begin
                $error("digest_word expected %h actual %h", row.word0,
                       digest_queue[digest_queue.size()-8].word);
                fail_count++;
            end
        end

        // Marker in the last slot: the length spills into a second block
        send_message(63, 1'($urandom_range(0, 1)));

        // Hold off until every digest word has come out
        drain_digests();

        // Full block on the end item: padding fills a block of its own
        send_message(64, 1'b1);

        // Random messages, all short
        for (int m = 0; m < 4; m++)
            send_message($urandom_range(0, 12), 1'($urandom_range(0, 1)));

        drain_digests();
        repeat (300) @(posedge clk);
        $display("Hashed %0d messages (empty, padding edges, two-block tails, random)", msgs_sent);
        $display("and checked %0d digest words under random stalls.", digests_seen);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Bound the run
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
